// ===== rtl/radix_integer_to_ascii_top_defines.svh =====
// Assertion macros shared by the radix integer to ASCII converter.
`ifndef RADIX_INTEGER_TO_ASCII_TOP_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RIT_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define RIT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RIT_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define RIT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== rtl/rit_pkg.sv =====
// Shared types, constants and helper functions of the radix integer to ASCII converter.
package rit_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_SLOTS_DEF = 32;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A = 7'h41;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic we;
		logic re;
		logic load;
		logic last;
	} store_ctl_t;

	function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DEC_LIMIT) begin
			res = ASCII_ZERO + CHAR_W'(d);
		end else begin
			res = ASCII_A + CHAR_W'(d - DEC_LIMIT);
		end
		return res;
	endfunction

endpackage

// ===== rtl/rit_div.sv =====
// Bit-serial restoring divider that yields one digit of the value per pass.
module rit_div #(
	parameter int VALUE_BITS = rit_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  rit_pkg::div_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [rit_pkg::RADIX_W-1:0]   radix,
	output logic [rit_pkg::DIGIT_W-1:0]   rem,
	output logic                          nz
);
	import rit_pkg::*;

	logic [VALUE_BITS-1:0] q_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic                  nz_q;
	logic [RADIX_W-1:0]    partial;
	logic [RADIX_W-1:0]    diff;
	logic                  ge;

	assign partial = {rem_q, q_q[VALUE_BITS-1]};
	assign diff    = partial - radix;
	assign ge      = (partial >= radix);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q   <= value;
			rem_q <= '0;
			nz_q  <= 1'b0;
		end else if (ctl.start) begin
			rem_q <= '0;
			nz_q  <= 1'b0;
		end else if (ctl.step) begin
			q_q   <= {q_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
			nz_q  <= nz_q | ge;
		end
	end

	assign rem = rem_q;
	assign nz  = nz_q;

endmodule

// ===== rtl/rit_store.sv =====
// Digit store memory and registered character output stage.
module rit_store #(
	parameter int DIGIT_SLOTS = rit_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rit_pkg::store_ctl_t               ctl,
	input  logic [$clog2(DIGIT_SLOTS)-1:0]    waddr,
	input  logic [rit_pkg::DIGIT_W-1:0]       wdata,
	input  logic [$clog2(DIGIT_SLOTS)-1:0]    raddr,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rit_pkg::CHAR_W-1:0]        digit_char,
	output logic                              last_digit
);
	import rit_pkg::*;

	logic [DIGIT_W-1:0] mem [DIGIT_SLOTS];
	logic [DIGIT_W-1:0] rdata_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               valid_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
		if (ctl.load) begin
			char_q <= digit_to_ascii(rdata_q);
			last_q <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid  = valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

// ===== rtl/radix_integer_to_ascii_top.sv =====
// Each digit is divided out bit-serially over all VALUE_BITS bits of the value and then
// written to the digit store; each character is then read back from the store and loaded
// into the output register, and the load waits while the output is stalled. The next
// request is taken once the last character is in the output register. Reset clears
// control state and the digit count and sets the radix to ten; the digit store is not
// cleared.
`include "radix_integer_to_ascii_top_defines.svh"

module radix_integer_to_ascii_top #(
	parameter int VALUE_BITS  = rit_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_SLOTS = rit_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rit_pkg::RADIX_W-1:0]     cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [VALUE_BITS-1:0]           value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rit_pkg::CHAR_W-1:0]      digit_char,
	output logic                            last_digit
);
	import rit_pkg::*;

	localparam int IDX_W = $clog2(DIGIT_SLOTS);
	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
	localparam int BIT_W = $clog2(VALUE_BITS);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(DIGIT_SLOTS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_STORE = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_LD    = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [CNT_W-1:0]   n_q, n_d;
	logic [IDX_W-1:0]   ridx_q, ridx_d;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] radix_eff;
	logic [DIGIT_W-1:0] div_rem;
	logic               div_nz;
	logic               accept;
	logic               out_free;
	div_ctl_t           div_ctl;
	store_ctl_t         st_ctl;

	assign radix_eff = radix_clamp(radix_q);
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		bit_d   = bit_q;
		n_d     = n_q;
		ridx_d  = ridx_q;
		div_ctl = '0;
		st_ctl  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					div_ctl.load = 1'b1;
					bit_d        = '0;
					n_d          = '0;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				bit_d        = bit_q + 1'b1;
				if (bit_q == BIT_LAST) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				st_ctl.we = 1'b1;
				n_d       = n_q + 1'b1;
				bit_d     = '0;
				if (!div_nz || (n_q + 1'b1) == SLOTS_C) begin
					ridx_d  = n_q[IDX_W-1:0];
					state_d = ST_RD;
				end else begin
					div_ctl.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_RD: begin
				st_ctl.re = 1'b1;
				state_d   = ST_LD;
			end
			ST_LD: begin
				if (out_free) begin
					st_ctl.load = 1'b1;
					st_ctl.last = (ridx_q == '0);
					if (ridx_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						ridx_d  = ridx_q - 1'b1;
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			n_q     <= '0;
			ridx_q  <= '0;
			radix_q <= RADIX_RESET;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			n_q     <= n_d;
			ridx_q  <= ridx_d;
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
		end
	end

	rit_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk   (clk),
		.ctl   (div_ctl),
		.value (value),
		.radix (radix_eff),
		.rem   (div_rem),
		.nz    (div_nz)
	);

	rit_store #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (st_ctl),
		.waddr      (n_q[IDX_W-1:0]),
		.wdata      (div_rem),
		.raddr      (ridx_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	`RIT_ASSERT_NEXT(a_accept_starts_div, clk, arst_n, accept, (state_q == ST_DIV) && (bit_q == '0), "request did not start a division")
	`RIT_ASSERT(a_count_bound, clk, arst_n, n_q <= SLOTS_C, "digit count exceeds the store depth")
	`RIT_ASSERT(a_no_overwrite, clk, arst_n, !st_ctl.load || !out_valid || !out_stall, "output register overwritten while stalled")
	`RIT_ASSERT_NEXT(a_last_ends, clk, arst_n, (state_q == ST_LD) && out_free && (ridx_q == '0), (state_q == ST_IDLE) && out_valid && last_digit, "final character not flagged")

endmodule
